// ===== src/arw_pkg.sv =====
// Shared types and constants for the anti-replay window block.
package arw_pkg;

    localparam int COUNTER_W   = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [COUNTER_W-1:0] counter;
        logic                 is_zero;
    } arw_item_t;

    typedef struct packed {
        logic item_valid;
        logic full;
    } arw_queue_status_t;

endpackage

// ===== src/arw_front.sv =====
// Front end: input transfer, zero-counter classification and item queue.
module arw_front
    import arw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 counter_valid,
    output logic                 counter_stall,
    input  logic [COUNTER_W-1:0] counter,
    input  logic                 pop,
    output arw_queue_status_t    status,
    output arw_item_t            item
);

    arw_item_t              queue_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic [QUEUE_PTR_W:0]   count_next;
    logic                   push;
    logic                   pop_ok;
    arw_item_t              new_item;

    assign status.full       = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign status.item_valid = (count_reg != '0);
    assign counter_stall     = status.full;
    assign push              = counter_valid && !status.full;
    assign pop_ok            = pop && status.item_valid;

    assign new_item.counter = counter;
    assign new_item.is_zero = (counter == '0);

    assign item = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = QUEUE_PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = QUEUE_PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop_ok)
        begin
            count_next = (QUEUE_PTR_W+1)'(count_reg + 1'b1);
        end
        else if (!push && pop_ok)
        begin
            count_next = (QUEUE_PTR_W+1)'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== src/arw_back.sv =====
// Back end: window state, replay check and result register.
module arw_back
    import arw_pkg::*;
#(
    parameter int WINDOW_BITS = 128
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  arw_queue_status_t status,
    input  arw_item_t         item,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output logic              accepted,
    output logic              advanced
);

    localparam int IDX_W = $clog2(WINDOW_BITS);

    logic                   started_reg;
    logic                   started_next;
    logic [COUNTER_W-1:0]   highest_reg;
    logic [COUNTER_W-1:0]   highest_next;
    logic [WINDOW_BITS-1:0] window_reg;
    logic [WINDOW_BITS-1:0] window_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   accepted_reg;
    logic                   accepted_next;
    logic                   advanced_reg;
    logic                   advanced_next;

    logic [COUNTER_W:0]     diff;
    logic [COUNTER_W-1:0]   age;
    logic                   is_higher;
    logic                   far_ahead;
    logic                   in_window;
    logic [IDX_W-1:0]       age_idx;

    assign pop = status.item_valid && (!out_valid_reg || !result_stall);

    assign diff      = {1'b0, item.counter} - {1'b0, highest_reg};
    assign age       = highest_reg - item.counter;
    assign is_higher = !diff[COUNTER_W] && (diff[COUNTER_W-1:0] != '0);
    assign far_ahead = (diff[COUNTER_W-1:0] >= COUNTER_W'(WINDOW_BITS));
    assign in_window = (age < COUNTER_W'(WINDOW_BITS));
    assign age_idx   = age[IDX_W-1:0];

    always_comb
    begin
        started_next   = started_reg;
        highest_next   = highest_reg;
        window_next    = window_reg;
        out_valid_next = out_valid_reg && result_stall;
        accepted_next  = accepted_reg;
        advanced_next  = advanced_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            accepted_next  = 1'b0;
            advanced_next  = 1'b0;
            if (item.is_zero)
            begin
                accepted_next = 1'b0;
            end
            else if (!started_reg || is_higher)
            begin
                started_next  = 1'b1;
                highest_next  = item.counter;
                accepted_next = 1'b1;
                advanced_next = 1'b1;
                if (!started_reg || far_ahead)
                begin
                    window_next = WINDOW_BITS'(1);
                end
                else
                begin
                    window_next = (window_reg << diff[IDX_W-1:0]) | WINDOW_BITS'(1);
                end
            end
            else if (in_window && !window_reg[age_idx])
            begin
                window_next[age_idx] = 1'b1;
                accepted_next        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            highest_reg   <= '0;
            window_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            started_reg   <= started_next;
            highest_reg   <= highest_next;
            window_reg    <= window_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accepted_reg <= accepted_next;
        advanced_reg <= advanced_next;
    end

    assign result_valid = out_valid_reg;
    assign accepted     = accepted_reg;
    assign advanced     = advanced_reg;

endmodule

// ===== src/anti_replay_window.sv =====
// Top level of the sliding-window anti-replay checker.
// Input channel: counter_valid / counter_stall carry one 64-bit sequence
// counter per transfer. Output channel: result_valid / result_stall carry
// accepted and advanced for each counter, in arrival order.
// A counter entering the four-entry queue waits in a queue entry until the
// back end pops it and registers its result. Throughput is one counter per
// cycle while result_stall is low: the back end checks and updates the
// window as it pops each queue entry. With result_stall high over a valid
// result, the result register holds and the back end stops draining the
// queue; counter_stall rises once the queue holds four entries. Reset
// clears the started flag, the highest counter and all window marks; the
// queue and result register come up empty. The first nonzero counter after
// reset starts the window. WINDOW_BITS sets the window width.
module anti_replay_window
    import arw_pkg::*;
#(
    parameter int WINDOW_BITS = 128
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 counter_valid,
    output logic                 counter_stall,
    input  logic [COUNTER_W-1:0] counter,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 accepted,
    output logic                 advanced
);

    arw_queue_status_t status;
    arw_item_t         item;
    logic              pop;

    arw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .counter_valid (counter_valid),
        .counter_stall (counter_stall),
        .counter       (counter),
        .pop           (pop),
        .status        (status),
        .item          (item)
    );

    arw_back #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .status       (status),
        .item         (item),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .accepted     (accepted),
        .advanced     (advanced)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!advanced || accepted))
        else $error("advanced without accepted");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |-> !pop)
        else $error("queue drained into a stalled result");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(counter_stall) |-> $past(counter_valid))
        else $error("queue filled without an input transfer");
`endif

endmodule

// ===== tb/sv/anti_replay_window_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the 128-bit sliding-window anti-replay checker.
module anti_replay_window_test;
    import arw_pkg::*;

    localparam int WINDOW_BITS = 128;
    localparam logic [COUNTER_W-1:0] TOP_COUNTER = '1;

    typedef struct {
        logic [COUNTER_W-1:0] value;
        bit                   hold_for_drain;
    } probe_t;

    typedef struct {
        logic [COUNTER_W-1:0] value;
        logic                 accepted;
        logic                 advanced;
    } verdict_t;

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 counter_valid = 1'b0;
    logic                 counter_stall;
    logic [COUNTER_W-1:0] counter       = '0;
    logic                 result_valid;
    logic                 result_stall  = 1'b0;
    logic                 accepted;
    logic                 advanced;

    probe_t   counters_to_send[$];
    verdict_t verdicts_due[$];

    // window state mirror
    bit                   window_started;
    logic [COUNTER_W-1:0] window_top;
    logic [WINDOW_BITS-1:0] window_marks;

    int mismatches;
    int results_seen;
    int accepted_seen;
    int advanced_seen;
    int counters_sent;
    int send_idle_left;
    int send_calm;
    int stall_left;
    int stall_calm;

    anti_replay_window #(
        .WINDOW_BITS(WINDOW_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .counter_valid (counter_valid),
        .counter_stall (counter_stall),
        .counter       (counter),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .accepted      (accepted),
        .advanced      (advanced)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_pause(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 70)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 2);
        if (roll < 97)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 20)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    task automatic predict_window(input logic [COUNTER_W-1:0] value);
        verdict_t             due;
        logic [COUNTER_W-1:0] lift;
        logic [COUNTER_W-1:0] age;
        due.value    = value;
        due.accepted = 1'b0;
        due.advanced = 1'b0;
        if (value == '0)
            ;
        else if (!window_started)
        begin
            window_started  = 1'b1;
            window_top      = value;
            window_marks    = '0;
            window_marks[0] = 1'b1;
            due.accepted    = 1'b1;
            due.advanced    = 1'b1;
        end
        else if (value > window_top)
        begin
            lift = value - window_top;
            if (lift >= WINDOW_BITS)
                window_marks = '0;
            else
                window_marks = window_marks << lift;
            window_marks[0] = 1'b1;
            window_top      = value;
            due.accepted    = 1'b1;
            due.advanced    = 1'b1;
        end
        else
        begin
            age = window_top - value;
            if (age < WINDOW_BITS && !window_marks[int'(age)])
            begin
                window_marks[int'(age)] = 1'b1;
                due.accepted            = 1'b1;
            end
        end
        verdicts_due.push_back(due);
    endtask

    task automatic check_result(input logic got_accepted, input logic got_advanced);
        verdict_t due;
        if (verdicts_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result accepted=%b advanced=%b",
                                      got_accepted, got_advanced));
            return;
        end
        due = verdicts_due.pop_front();
        results_seen++;
        if (got_accepted !== due.accepted)
            report_mismatch($sformatf("counter %h: accepted=%b, want %b",
                                      due.value, got_accepted, due.accepted));
        if (got_advanced !== due.advanced)
            report_mismatch($sformatf("counter %h: advanced=%b, want %b",
                                      due.value, got_advanced, due.advanced));
        if (due.accepted)
            accepted_seen++;
        if (due.advanced)
            advanced_seen++;
    endtask

    task automatic queue_counter(input logic [COUNTER_W-1:0] value, input bit hold);
        probe_t probe;
        probe.value          = value;
        probe.hold_for_drain = hold;
        counters_to_send.push_back(probe);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        probe_t next;
        if (!rst_n)
        begin
            counter_valid <= 1'b0;
            counter       <= '0;
        end
        else
        begin
            if (counter_valid && !counter_stall)
            begin
                predict_window(counter);
                counters_sent++;
                send_idle_left = draw_pause(send_calm);
            end
            if (!(counter_valid && counter_stall))
            begin
                if (send_idle_left > 0)
                begin
                    send_idle_left--;
                    counter_valid <= 1'b0;
                end
                else if (counters_to_send.size() != 0 &&
                         !(counters_to_send[0].hold_for_drain && verdicts_due.size() != 0))
                begin
                    next = counters_to_send.pop_front();
                    counter_valid <= 1'b1;
                    counter       <= next.value;
                end
                else
                    counter_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
                check_result(accepted, advanced);
            if (stall_left == 0)
                stall_left = draw_pause(stall_calm);
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    initial
    begin
        logic [COUNTER_W-1:0] reach;
        logic [COUNTER_W-1:0] value;
        logic [COUNTER_W-1:0] step;
        logic [COUNTER_W-1:0] recent[$];
        int                   roll;
        int                   pick;

        // zero before start, start, replays, window edges, word-boundary slides
        queue_counter(64'd0, 1'b0);
        queue_counter(64'd1000, 1'b0);
        queue_counter(64'd1000, 1'b0);
        queue_counter(64'd999, 1'b0);
        queue_counter(64'd999, 1'b0);
        queue_counter(64'd873, 1'b0);
        queue_counter(64'd872, 1'b0);
        queue_counter(64'd1001, 1'b0);
        queue_counter(64'd873, 1'b0);
        queue_counter(64'd1065, 1'b0);
        queue_counter(64'd1002, 1'b0);
        queue_counter(64'd1001, 1'b0);
        queue_counter(64'd1192, 1'b0);
        queue_counter(64'd1065, 1'b0);
        queue_counter(64'd1320, 1'b0);
        queue_counter(64'd1192, 1'b0);
        queue_counter(64'd1319, 1'b0);

        reach = 64'd1320;
        for (int i = 0; i < 430; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    step = COUNTER_W'($urandom_range(1, 3));
                else if (pick < 75)
                    step = COUNTER_W'($urandom_range(4, 70));
                else if (pick < 93)
                    step = COUNTER_W'($urandom_range(120, 140));
                else
                    step = {$urandom, $urandom} >> $urandom_range(8, 40);
                if (step == '0)
                    step = 64'd1;
                reach = reach + step;
                value = reach;
            end
            else if (roll < 85)
                value = reach - COUNTER_W'($urandom_range(0, 140));
            else if (roll < 93 && recent.size() != 0)
                value = recent[$urandom_range(0, recent.size() - 1)];
            else if (roll < 97)
                value = reach - COUNTER_W'($urandom_range(128, 1000));
            else
                value = '0;
            queue_counter(value, (i % 100) == 50);
            recent.push_back(value);
            if (recent.size() > 32)
                void'(recent.pop_front());
        end

        // counter extremes once the random walk is done
        queue_counter(TOP_COUNTER, 1'b1);
        queue_counter(TOP_COUNTER - 64'd1, 1'b0);
        queue_counter(64'h8000_0000_0000_0000, 1'b0);
        queue_counter(64'd0, 1'b0);
        queue_counter(TOP_COUNTER, 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (counters_to_send.size() != 0 || counter_valid)
            @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d counters; checked %0d results: %0d accepted, %0d advanced the top,",
                 counters_sent, results_seen, accepted_seen, advanced_seen);
        $display("%0d rejected as zero, replayed or too old.", results_seen - accepted_seen);
        if (mismatches == 0)
            $display("anti_replay_window_test passed");
        else
            $display("anti_replay_window_test failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Timeout with %0d results still due", verdicts_due.size());
        $display("anti_replay_window_test failed");
        $finish;
    end

endmodule
